FILE: design/ifbph_pkg.sv
// Shared constants, codes and controller/datapath types for the IIR filter bank.
// No dependencies; the controller, datapath, top level and testbench import this package.
package ifbph_pkg;

    localparam int NUM_FILTERS_MAX  = 32;
    localparam int ORDER_MAX        = 6;
    localparam int COEFS_PER_FILTER = 2 * ORDER_MAX + 1;
    localparam int COEF_DEPTH       = NUM_FILTERS_MAX * COEFS_PER_FILTER;
    localparam int DELAY_DEPTH      = NUM_FILTERS_MAX * ORDER_MAX;
    localparam int FILT_W           = $clog2(NUM_FILTERS_MAX);
    localparam int COEF_AW          = $clog2(COEF_DEPTH);
    localparam int DELAY_AW         = $clog2(DELAY_DEPTH);
    localparam int ORD_W            = 3;
    localparam int NF_W             = 6;
    localparam int AGE_W            = 17;
    localparam int PERIOD_W         = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 6;

    localparam logic [3:0] COEF_IDX_PERIOD = 4'(COEFS_PER_FILTER);

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_SAMPLE = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_FILTERS = 1'b0,
        REG_ORDER       = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B0,
        ST_MB0,
        ST_Y,
        ST_BK,
        ST_MBK,
        ST_MAK,
        ST_WZ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                load;
        logic                clear;
        logic                take_x;
        logic [COEF_AW-1:0]  coef_addr;
        logic [DELAY_AW-1:0] z_raddr;
        logic                mul_x;
        logic                mul_y;
        logic                latch_z;
        logic                z_zero;
        logic                calc_y;
        logic                add_acc;
        logic                write_z;
        logic [DELAY_AW-1:0] z_waddr;
        logic                emit;
        logic [FILT_W-1:0]   filt;
        logic                last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_stat_t;

endpackage

FILE: design/ifbph_stream_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface ifbph_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [4:0]         filter_index;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [15:0] sample;

    modport source (output valid, func, filter_index, coef_index, coef_value, sample,
                    input ready);
    modport sink   (input valid, func, filter_index, coef_index, coef_value, sample,
                    output ready);
endinterface

interface ifbph_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         filter_index_res;
    logic signed [23:0] y;
    logic signed [23:0] y_rect;
    logic               last;

    modport source (output valid, filter_index_res, y, y_rect, last, input ready);
    modport sink   (input valid, filter_index_res, y, y_rect, last, output ready);
endinterface

FILE: design/ifbph_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ifbph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/ifbph_ctrl.sv
// Sequencer for the filter bank: config registers, per-filter step control.
// Depends on ifbph_pkg; drives the datapath through dp_cmd_t.
module ifbph_ctrl
    import ifbph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic [1:0]            in_func,
    output logic                  in_ready,
    output dp_cmd_t               cmd,
    input  dp_stat_t              stat
);

    state_t              state_reg, state_next;
    logic [NF_W-1:0]     nf_reg;
    logic [ORD_W-1:0]    ord_reg;
    logic [FILT_W-1:0]   f_reg, f_next;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [COEF_AW-1:0]  cbase_reg, cbase_next;
    logic [DELAY_AW-1:0] dbase_reg, dbase_next;
    logic [NF_W-1:0]     nf_eff;
    logic [ORD_W-1:0]    ord_eff;
    logic                accept;
    logic                k_last;
    logic                f_last;

    always_comb
    begin
        if (nf_reg == '0)
        begin
            nf_eff = NF_W'(1);
        end
        else if (nf_reg > NF_W'(NUM_FILTERS_MAX))
        begin
            nf_eff = NF_W'(NUM_FILTERS_MAX);
        end
        else
        begin
            nf_eff = nf_reg;
        end
        if (ord_reg < ORD_W'(2))
        begin
            ord_eff = ORD_W'(2);
        end
        else if (ord_reg > ORD_W'(ORDER_MAX))
        begin
            ord_eff = ORD_W'(ORDER_MAX);
        end
        else
        begin
            ord_eff = ord_reg;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign k_last   = (k_reg + ORD_W'(1)) == ord_eff;
    assign f_last   = (NF_W'(f_reg) + NF_W'(1)) == nf_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg  <= NF_W'(NUM_FILTERS_MAX);
            ord_reg <= ORD_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_NUM_FILTERS: nf_reg  <= cfg_data;
                REG_ORDER:       ord_reg <= cfg_data[ORD_W-1:0];
                default:         nf_reg  <= nf_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            f_reg     <= '0;
            k_reg     <= '0;
            cbase_reg <= '0;
            dbase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            f_reg     <= f_next;
            k_reg     <= k_next;
            cbase_reg <= cbase_next;
            dbase_reg <= dbase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        f_next     = f_reg;
        k_next     = k_reg;
        cbase_next = cbase_reg;
        dbase_next = dbase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && func_t'(in_func) == FUNC_SAMPLE)
                begin
                    state_next = ST_B0;
                    f_next     = '0;
                    cbase_next = '0;
                    dbase_next = '0;
                end
            end
            ST_B0:  state_next = ST_MB0;
            ST_MB0: state_next = ST_Y;
            ST_Y:
            begin
                state_next = ST_BK;
                k_next     = '0;
            end
            ST_BK:  state_next = ST_MBK;
            ST_MBK: state_next = ST_MAK;
            ST_MAK: state_next = ST_WZ;
            ST_WZ:
            begin
                if (k_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_BK;
                    k_next     = k_reg + ORD_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_full)
                begin
                    if (f_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_B0;
                        f_next     = f_reg + FILT_W'(1);
                        cbase_next = cbase_reg + COEF_AW'(COEFS_PER_FILTER);
                        dbase_next = dbase_reg + DELAY_AW'(ORDER_MAX);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.filt    = f_reg;
        cmd.last    = f_last;
        cmd.z_waddr = dbase_reg + DELAY_AW'(k_reg);
        cmd.load    = accept && func_t'(in_func) == FUNC_LOAD;
        cmd.clear   = accept && func_t'(in_func) == FUNC_CLEAR;
        cmd.take_x  = accept && func_t'(in_func) == FUNC_SAMPLE;
        unique case (state_reg)
            ST_B0:
            begin
                cmd.coef_addr = cbase_reg;
                cmd.z_raddr   = dbase_reg;
            end
            ST_MB0:
            begin
                cmd.mul_x   = 1'b1;
                cmd.latch_z = 1'b1;
            end
            ST_Y:
            begin
                cmd.calc_y = 1'b1;
            end
            ST_BK:
            begin
                cmd.coef_addr = cbase_reg + COEF_AW'(k_reg) + COEF_AW'(1);
                cmd.z_raddr   = k_last ? dbase_reg
                                       : dbase_reg + DELAY_AW'(k_reg) + DELAY_AW'(1);
            end
            ST_MBK:
            begin
                cmd.mul_x     = 1'b1;
                cmd.latch_z   = 1'b1;
                cmd.z_zero    = k_last;
                cmd.coef_addr = cbase_reg + COEF_AW'(k_reg) + COEF_AW'(ORDER_MAX + 1);
            end
            ST_MAK:
            begin
                cmd.add_acc = 1'b1;
                cmd.mul_y   = 1'b1;
            end
            ST_WZ:
            begin
                cmd.write_z = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = !stat.out_full;
            end
            default:
            begin
                cmd.coef_addr = '0;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !stat.out_full)
        else $error("result emitted into a full output register");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after last filter");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !(cmd.load || cmd.clear || cmd.take_x))
        else $error("item transfer while a sample is in progress");

endmodule

FILE: design/ifbph_dp.sv
// Datapath: coefficient and delay RAMs, shared multiplier, saturation, peak hold,
// output register. Depends on ifbph_pkg, ifbph_ram and ifbph_out_if.
module ifbph_dp
    import ifbph_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [4:0]         in_filter_index,
    input  logic [3:0]         in_coef_index,
    input  logic signed [31:0] in_coef_value,
    input  logic signed [15:0] in_sample,
    ifbph_out_if.source        out_ch
);

    logic signed [31:0]      coef_rdata;
    logic [55:0]             z_rdata;
    logic                    coef_we;
    logic [COEF_AW-1:0]      coef_waddr;
    logic [DELAY_DEPTH-1:0]  zvalid_reg;
    logic                    zv_reg;
    logic [PERIOD_W-1:0]     period_reg [NUM_FILTERS_MAX];
    logic signed [23:0]      peak_reg [NUM_FILTERS_MAX];
    logic [AGE_W-1:0]        age_reg [NUM_FILTERS_MAX];
    logic signed [15:0]      x_reg;
    logic signed [55:0]      prod_reg;
    logic signed [55:0]      zn_reg;
    logic signed [57:0]      acc_reg;
    logic signed [23:0]      y_reg;
    logic signed [23:0]      mul_b;
    logic signed [55:0]      mul_p;
    logic signed [57:0]      sum_w;
    logic signed [57:0]      rnd_w;
    logic signed [57:0]      t_w;
    logic signed [23:0]      y_sat;
    logic [55:0]             z_sat;
    logic signed [23:0]      peak_cur;
    logic [AGE_W-1:0]        age_cur;
    logic [AGE_W-1:0]        age_inc;
    logic                    take_new;
    logic signed [23:0]      rect_w;
    logic signed [23:0]      peak_next;
    logic [AGE_W-1:0]        age_next;
    logic                    out_valid_reg;
    logic [FILT_W-1:0]       out_fi_reg;
    logic signed [23:0]      out_y_reg;
    logic signed [23:0]      out_rect_reg;
    logic                    out_last_reg;

    assign coef_we    = cmd.load && in_coef_index < COEF_IDX_PERIOD;
    assign coef_waddr = COEF_AW'(in_filter_index) * COEF_AW'(COEFS_PER_FILTER)
                        + COEF_AW'(in_coef_index);

    ifbph_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (in_coef_value),
        .raddr (cmd.coef_addr),
        .rdata (coef_rdata)
    );

    ifbph_ram #(.WIDTH(56), .DEPTH(DELAY_DEPTH)) u_delay_ram (
        .clk   (clk),
        .we    (cmd.write_z),
        .waddr (cmd.z_waddr),
        .wdata (z_sat),
        .raddr (cmd.z_raddr),
        .rdata (z_rdata)
    );

    assign mul_b = cmd.mul_y ? y_reg : 24'(x_reg);
    assign mul_p = coef_rdata * mul_b;
    assign sum_w = 58'(prod_reg) + 58'(zn_reg);
    assign rnd_w = (sum_w + 58'sd8388608) >>> 24;
    assign t_w   = acc_reg - 58'(prod_reg);

    always_comb
    begin
        if ((&rnd_w[57:23]) || !(|rnd_w[57:23]))
        begin
            y_sat = rnd_w[23:0];
        end
        else if (rnd_w[57])
        begin
            y_sat = {1'b1, 23'd0};
        end
        else
        begin
            y_sat = {1'b0, {23{1'b1}}};
        end
        if ((&t_w[57:55]) || !(|t_w[57:55]))
        begin
            z_sat = t_w[55:0];
        end
        else if (t_w[57])
        begin
            z_sat = {1'b1, 55'd0};
        end
        else
        begin
            z_sat = {1'b0, {55{1'b1}}};
        end
    end

    assign peak_cur = peak_reg[cmd.filt];
    assign age_cur  = age_reg[cmd.filt];
    assign age_inc  = (&age_cur) ? age_cur : age_cur + AGE_W'(1);
    assign take_new = (y_reg > peak_cur) || (age_cur > AGE_W'(period_reg[cmd.filt]));

    always_comb
    begin
        priority if (take_new && y_reg[23])
        begin
            rect_w    = '0;
            peak_next = peak_cur;
            age_next  = age_inc;
        end
        else if (take_new)
        begin
            rect_w    = y_reg;
            peak_next = y_reg;
            age_next  = AGE_W'(1);
        end
        else
        begin
            rect_w    = peak_cur;
            peak_next = peak_cur;
            age_next  = age_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_coef_index == COEF_IDX_PERIOD)
        begin
            period_reg[in_filter_index] <= in_coef_value[PERIOD_W-1:0];
        end
        if (cmd.take_x)
        begin
            x_reg <= in_sample;
        end
        if (cmd.mul_x || cmd.mul_y)
        begin
            prod_reg <= mul_p;
        end
        zv_reg <= zvalid_reg[cmd.z_raddr];
        if (cmd.latch_z)
        begin
            zn_reg <= (cmd.z_zero || !zv_reg) ? '0 : z_rdata;
        end
        if (cmd.add_acc)
        begin
            acc_reg <= sum_w;
        end
        if (cmd.calc_y)
        begin
            y_reg <= y_sat;
        end
        if (cmd.emit)
        begin
            out_fi_reg   <= cmd.filt;
            out_y_reg    <= y_reg;
            out_rect_reg <= rect_w;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FILTERS_MAX; i++)
            begin
                peak_reg[i] <= '0;
                age_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                zvalid_reg <= '0;
                for (int i = 0; i < NUM_FILTERS_MAX; i++)
                begin
                    peak_reg[i] <= '0;
                    age_reg[i]  <= '0;
                end
            end
            else
            begin
                if (cmd.write_z)
                begin
                    zvalid_reg[cmd.z_waddr] <= 1'b1;
                end
                if (cmd.emit)
                begin
                    peak_reg[cmd.filt] <= peak_next;
                    age_reg[cmd.filt]  <= age_next;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_full           = out_valid_reg && !out_ch.ready;
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.filter_index_res = out_fi_reg;
    assign out_ch.y                = out_y_reg;
    assign out_ch.y_rect           = out_rect_reg;
    assign out_ch.last             = out_last_reg;

    a_wz_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_z |-> $past(cmd.add_acc))
        else $error("delay write without a fresh accumulation");

    a_rect_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.emit) && !$past(cmd.clear) |-> !out_rect_reg[23] || !$past(y_reg[23]))
        else $error("negative peak-held value");

    a_calc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc_y |-> $past(cmd.mul_x) && $past(cmd.latch_z))
        else $error("output computed without its product");

endmodule

FILE: design/iir_filter_bank_peak_hold.sv
// Top level of the IIR filter bank with peak hold: sequencer plus datapath.
// Depends on ifbph_pkg, ifbph_stream_if, ifbph_ctrl, ifbph_dp.
//
//   channel   dir   payload                                         transfer
//   in_ch     in    func, filter_index, coef_index, coef_value,     valid & ready
//                   sample
//   out_ch    out   filter_index_res, y, y_rect, last               valid & ready
//   cfg       in    cfg_we, cfg_index, cfg_data                     cfg_we
//
// A load or clear item completes on its transfer. A sample runs filter by filter, step by
// step, paced by the shared multiplier and the single delay RAM read per recurrence step;
// no new item is taken until the last filter's result is emitted.
// Reset clears filter state at once through valid bits, and peaks and ages directly; no sweep.
// A stalled output holds the sequencer at the end of the next filter.
module iir_filter_bank_peak_hold
    import ifbph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ifbph_in_if.sink              in_ch,
    ifbph_out_if.source           out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ifbph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ifbph_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_filter_index (in_ch.filter_index),
        .in_coef_index   (in_ch.coef_index),
        .in_coef_value   (in_ch.coef_value),
        .in_sample       (in_ch.sample),
        .out_ch          (out_ch)
    );

endmodule

FILE: sim/iir_filter_bank_peak_hold_test.sv
// Testbench for iir_filter_bank_peak_hold: directed table, then random phases under
// several bank sizes and orders, with every result checked against a bit-true predictor.
// Depends on ifbph_pkg, ifbph_stream_if and the design top level.
module iir_filter_bank_peak_hold_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ifbph_pkg::*;

    localparam logic [3:0] CI_B0     = 4'd0;
    localparam logic [3:0] CI_A1     = 4'(ORDER_MAX + 1);
    localparam logic [3:0] CI_PERIOD = COEF_IDX_PERIOD;
    localparam logic [3:0] CI_BAD    = 4'd15;
    localparam longint Z_HI = 64'sd36028797018963967;
    localparam longint Z_LO = -64'sd36028797018963968;
    localparam longint Y_HI = 64'sd8388607;
    localparam longint Y_LO = -64'sd8388608;

    typedef struct {
        func_t       func;
        logic [4:0]  fi;
        logic [3:0]  ci;
        logic [31:0] val;
        logic [15:0] smp;
    } bank_item_t;

    typedef struct {
        logic [4:0]  fi;
        logic [23:0] y;
        logic [23:0] rect;
        logic        last;
    } bank_res_t;

    typedef struct {
        logic        is_cfg;
        cfg_reg_t    reg_sel;
        func_t       func;
        logic [4:0]  fi;
        logic [3:0]  ci;
        logic [31:0] val;
        logic [15:0] smp;
        logic        chk;
        logic [23:0] ey;
        logic [23:0] er;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ifbph_in_if  in_ch ();
    ifbph_out_if out_ch ();

    iir_filter_bank_peak_hold u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic signed [31:0] coef_mem [NUM_FILTERS_MAX][COEFS_PER_FILTER];
    logic [15:0]        period_mem [NUM_FILTERS_MAX];
    longint             delay_mem [NUM_FILTERS_MAX][ORDER_MAX];
    longint             peak_mem [NUM_FILTERS_MAX];
    int unsigned        age_mem [NUM_FILTERS_MAX];
    logic [5:0]         bank_nf;
    logic [2:0]         bank_ord;

    bank_res_t filter_results_q [$];
    int errors;
    int n_items;
    int n_results;
    bit quiet;
    int stall_req;
    int stall_taken;
    int hold_cnt;

    dir_row_t dir_tab [] = '{
        '{1, REG_NUM_FILTERS, FUNC_NOP, 0, 0, 32'd1, 0, 0, 0, 0},
        '{1, REG_ORDER, FUNC_NOP, 0, 0, 32'd2, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_B0, 32'h0100_0000, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_B0 + 4'd1, 32'h0, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_B0 + 4'd2, 32'h0, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_A1, 32'h0, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_A1 + 4'd1, 32'h0, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_PERIOD, 32'hFFFF_0000, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h7FFF, 1, 24'h007FFF, 24'h007FFF},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h8000, 1, 24'hFF8000, 24'h000000},
        '{0, REG_ORDER, FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h0000, 1, 24'h000000, 24'h000000},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_B0, 32'h8000_0000, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h8000, 1, 24'h400000, 24'h400000},
        '{0, REG_ORDER, FUNC_NOP, 5'd31, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 5'd31, CI_BAD, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_B0, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h7FFF, 0, 0, 0},
        '{0, REG_ORDER, FUNC_LOAD, 0, CI_A1, 32'h7FFF_FFFF, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h8000, 0, 0, 0},
        '{1, REG_NUM_FILTERS, FUNC_NOP, 0, 0, 32'd0, 0, 0, 0, 0},
        '{1, REG_ORDER, FUNC_NOP, 0, 0, 32'd0, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h1234, 0, 0, 0},
        '{1, REG_NUM_FILTERS, FUNC_NOP, 0, 0, 32'd63, 0, 0, 0, 0},
        '{1, REG_ORDER, FUNC_NOP, 0, 0, 32'd7, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'h7FFF, 0, 0, 0},
        '{1, REG_ORDER, FUNC_NOP, 0, 0, 32'd3, 0, 0, 0, 0},
        '{0, REG_ORDER, FUNC_SAMPLE, 0, 0, 0, 16'hC000, 0, 0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_err(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void clear_filters();
        for (int f = 0; f < NUM_FILTERS_MAX; f++)
        begin
            for (int k = 0; k < ORDER_MAX; k++)
                delay_mem[f][k] = 0;
            peak_mem[f] = 0;
            age_mem[f] = 0;
        end
    endfunction

    function automatic int filter_bank_step(input bank_item_t it);
        int nf;
        int ord;
        longint x;
        longint acc;
        longint y;
        longint rect;
        longint nxt;
        int unsigned age;
        bank_res_t r;
        nf = 0;
        case (it.func)
            FUNC_LOAD:
            begin
                if (it.ci == CI_PERIOD)
                    period_mem[it.fi] = it.val[15:0];
                else if (it.ci < CI_PERIOD)
                    coef_mem[it.fi][it.ci] = it.val;
            end
            FUNC_CLEAR:
                clear_filters();
            FUNC_SAMPLE:
            begin
                nf = (bank_nf < 1) ? 1 : ((bank_nf > NUM_FILTERS_MAX) ? NUM_FILTERS_MAX
                                                                       : int'(bank_nf));
                ord = (bank_ord < 2) ? 2 : ((bank_ord > ORDER_MAX) ? ORDER_MAX : int'(bank_ord));
                x = longint'($signed(it.smp));
                for (int f = 0; f < nf; f++)
                begin
                    age = age_mem[f];
                    acc = longint'(coef_mem[f][0]) * x + delay_mem[f][0];
                    y = clip((acc + 64'sd8388608) >>> 24, Y_LO, Y_HI);
                    for (int k = 0; k < ord; k++)
                    begin
                        nxt = (k + 1 < ord) ? delay_mem[f][k + 1] : 0;
                        delay_mem[f][k] = clip(longint'(coef_mem[f][k + 1]) * x + nxt
                                               - longint'(coef_mem[f][ORDER_MAX + 1 + k]) * y,
                                               Z_LO, Z_HI);
                    end
                    if (y > peak_mem[f] || age > period_mem[f])
                    begin
                        if (y < 0)
                        begin
                            rect = 0;
                            if (age < 131071) age++;
                        end
                        else
                        begin
                            peak_mem[f] = y;
                            rect = y;
                            age = 1;
                        end
                    end
                    else
                    begin
                        rect = peak_mem[f];
                        if (age < 131071) age++;
                    end
                    age_mem[f] = age;
                    r.fi = 5'(f);
                    r.y = y[23:0];
                    r.rect = rect[23:0];
                    r.last = (f + 1 == nf);
                    filter_results_q.push_back(r);
                end
            end
            default: ;
        endcase
        return nf;
    endfunction

    // result side: check every transfer, idle or hold off as asked
    always @(posedge clk or negedge rst_n)
    begin
        bank_res_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_cnt <= 0;
            stall_taken <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_results++;
                if (filter_results_q.size() == 0)
                    report_err($sformatf("unexpected result filter %0d", out_ch.filter_index_res));
                else
                begin
                    e = filter_results_q.pop_front();
                    if (out_ch.filter_index_res !== e.fi || out_ch.y !== e.y
                        || out_ch.y_rect !== e.rect || out_ch.last !== e.last)
                        report_err($sformatf("got f%0d y=%h r=%h l=%b, want f%0d y=%h r=%h l=%b",
                            out_ch.filter_index_res, out_ch.y, out_ch.y_rect, out_ch.last,
                            e.fi, e.y, e.rect, e.last));
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_ch.ready <= 1'b0;
            end
            else if (stall_req != stall_taken)
            begin
                stall_taken <= stall_req;
                hold_cnt <= 3000;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= quiet || ($urandom_range(0, 99) >= 27);
        end
    end

    task automatic push_item(input bank_item_t it, output int nres);
        while (!quiet && $urandom_range(0, 99) < 27)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= it.func;
        in_ch.filter_index <= it.fi;
        in_ch.coef_index <= it.ci;
        in_ch.coef_value <= it.val;
        in_ch.sample <= it.smp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_items++;
        nres = filter_bank_step(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (filter_results_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [5:0] value);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_NUM_FILTERS)
            bank_nf = value;
        else
            bank_ord = value[2:0];
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coef(input bit feedback);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return feedback ? 32'($signed($urandom) >>> 9) : 32'($signed($urandom) >>> 8);
    endfunction

    function automatic bank_item_t rand_item();
        bank_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it.fi = 5'($urandom);
        it.val = $urandom;
        it.smp = 16'($urandom);
        it.ci = 4'($urandom_range(0, 13));
        if (pick < 72)
        begin
            it.func = FUNC_SAMPLE;
            if ($urandom_range(0, 9) == 0)
                it.smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end
        else if (pick < 88)
        begin
            it.func = FUNC_LOAD;
            if (it.ci == CI_PERIOD)
                it.val = $urandom_range(0, 3) == 0 ? $urandom : {16'($urandom), 16'($urandom_range(0, 6))};
            else
                it.val = rand_coef(it.ci >= CI_A1);
            if ($urandom_range(0, 19) == 0)
                it.ci = $urandom_range(0, 1) ? CI_BAD : 4'd14;
        end
        else if (pick < 94)
            it.func = FUNC_CLEAR;
        else
            it.func = FUNC_NOP;
        return it;
    endfunction

    initial
    begin
        bank_item_t it;
        int nres;
        int phase_nf [5] = '{32, 1, 0, 0, 32};
        int phase_ord [5] = '{6, 2, 0, 0, 2};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_NOP;
        in_ch.filter_index = '0;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.sample = '0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        quiet = 1'b0;
        stall_req = 0;
        bank_nf = 6'd32;
        bank_ord = 3'd2;
        clear_filters();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every coefficient gets a value before any sample reads it
        for (int f = 0; f < NUM_FILTERS_MAX; f++)
            for (int c = 0; c < COEFS_PER_FILTER; c++)
            begin
                it.func = FUNC_LOAD;
                it.fi = 5'(f);
                it.ci = 4'(c);
                it.smp = '0;
                it.val = (4'(c) == CI_PERIOD) ? 32'($urandom_range(0, 6)) : rand_coef(4'(c) >= CI_A1);
                push_item(it, nres);
            end

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                drain();
                write_reg(dir_tab[i].reg_sel, dir_tab[i].val[5:0]);
            end
            else
            begin
                it.func = dir_tab[i].func;
                it.fi = dir_tab[i].fi;
                it.ci = dir_tab[i].ci;
                it.val = dir_tab[i].val;
                it.smp = dir_tab[i].smp;
                push_item(it, nres);
                if (dir_tab[i].chk && nres > 0)
                begin
                    filter_results_q[filter_results_q.size() - nres].y = dir_tab[i].ey;
                    filter_results_q[filter_results_q.size() - nres].rect = dir_tab[i].er;
                end
            end
        end

        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_reg(REG_NUM_FILTERS, phase_nf[p] != 0 ? 6'(phase_nf[p]) : 6'($urandom_range(1, 32)));
            write_reg(REG_ORDER, phase_ord[p] != 0 ? 6'(phase_ord[p]) : 6'($urandom_range(2, 6)));
            quiet = (p == 1);
            if (p == 2)
                stall_req++;
            for (int n = 0; n < 8; n++)
            begin
                if (p == 3 && n == 4)
                    drain();
                push_item(rand_item(), nres);
            end
        end
        quiet = 1'b0;

        in_ch.valid <= 1'b0;
        while (filter_results_q.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        $display("Run covered %0d input transfers and %0d result transfers over orders 2..6,",
                 n_items, n_results);
        $display("bank sizes 1..32, clears, bad load addresses and long output stalls.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
design/ifbph_pkg.sv
design/ifbph_stream_if.sv
design/ifbph_ram.sv
design/ifbph_ctrl.sv
design/ifbph_dp.sv
design/iir_filter_bank_peak_hold.sv
sim/iir_filter_bank_peak_hold_test.sv
